// ===== hdl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the Cyrillic byte code converter.
// Depends on nothing; the checks compile away when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Checks that a property holds at every rising edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Checks that a condition never holds at a rising edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// ===== hdl/utfcyr_pkg.sv =====
// Types, constants and the letter table of the Cyrillic byte code converter.
// Used by utfcyr_pair_dec and utf8_cyrillic_to_byte_code; depends on nothing.
`default_nettype none

package utfcyr_pkg;

  // Input word: one raw byte of the UTF-8 stream.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_word_t;

  // Output word: one converted or passed-through byte.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_converted;
    logic       out_last;
  } out_word_t;

  // Lead bytes of the two Cyrillic UTF-8 pages.
  localparam logic [7:0] LEAD_LOW  = 8'hD0;
  localparam logic [7:0] LEAD_HIGH = 8'hD1;

  // Tail payloads that encode IO on each page, and the tail that bounds
  // the letters: at or above it on the low page, below it on the high page.
  localparam logic [5:0] TAIL_IO_LOW  = 6'h01;
  localparam logic [5:0] TAIL_IO_HIGH = 6'h11;
  localparam logic [5:0] TAIL_SPLIT   = 6'h10;

  localparam logic [7:0] CODE_IO  = 8'd198;
  localparam logic [7:0] CODE_MIN = 8'd192;
  localparam logic [7:0] CODE_MAX = 8'd224;

  // Code of each letter by its offset from A, case folded.
  localparam logic [7:0] LETTER_CODE [0:31] = '{
    8'd192, 8'd193, 8'd194, 8'd195, 8'd196, 8'd197, 8'd199, 8'd200,
    8'd201, 8'd202, 8'd203, 8'd204, 8'd205, 8'd206, 8'd207, 8'd208,
    8'd209, 8'd210, 8'd211, 8'd212, 8'd213, 8'd215, 8'd216, 8'd214,
    8'd217, 8'd218, 8'd221, 8'd220, 8'd219, 8'd222, 8'd223, 8'd224
  };

  // Output queue geometry: one item may push two words.
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

endpackage

`default_nettype wire

// ===== hdl/utfcyr_pair_dec.sv =====
// Combinational decoder of a UTF-8 lead and tail byte into a letter code.
// Depends on utfcyr_pkg for the lead bytes, the tail constants and the table.
`default_nettype none

module utfcyr_pair_dec (
  input  logic [7:0] lead,
  input  logic [7:0] tail,
  output logic       hit,
  output logic [7:0] code
);

  logic [5:0] tail_bits;
  logic [4:0] letter_idx;

  assign tail_bits = tail[5:0];
  // Offset from A: both pages and both cases reduce to the tail minus 16, mod 32.
  assign letter_idx = {~tail_bits[4], tail_bits[3:0]};

  // Match the pair against the Cyrillic letter ranges of both pages.
  always_comb begin
    hit  = 1'b0;
    code = 8'd0;
    if (tail[7:6] == 2'b10) begin
      if (lead == utfcyr_pkg::LEAD_LOW) begin
        if (tail_bits == utfcyr_pkg::TAIL_IO_LOW) begin
          hit  = 1'b1;
          code = utfcyr_pkg::CODE_IO;
        end else if (tail_bits >= utfcyr_pkg::TAIL_SPLIT) begin
          hit  = 1'b1;
          code = utfcyr_pkg::LETTER_CODE[letter_idx];
        end
      end else if (lead == utfcyr_pkg::LEAD_HIGH) begin
        if (tail_bits == utfcyr_pkg::TAIL_IO_HIGH) begin
          hit  = 1'b1;
          code = utfcyr_pkg::CODE_IO;
        end else if (tail_bits < utfcyr_pkg::TAIL_SPLIT) begin
          hit  = 1'b1;
          code = utfcyr_pkg::LETTER_CODE[letter_idx];
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/utf8_cyrillic_to_byte_code.sv =====
// Top level of the UTF-8 Cyrillic letter to one-byte code converter.
// Depends on utfcyr_pkg, utfcyr_pair_dec and assert_macros.svh.
//
//   channel | direction | word type  | accepted when
//   --------+-----------+------------+---------------------------
//   in_     | input     | in_word_t  | in_valid and not in_stall
//   out_    | output    | out_word_t | out_valid and not out_stall
//
// One input word is taken per cycle while in_stall is low; its zero, one or two
// output words are written into a four-entry output queue at the same edge
// and drained one per cycle while out_stall is low.
// The input stalls only while the queue holds more than two words.
// Reset (rst_n low, synchronous) empties the queue and drops a held lead byte.
// A stall on the output holds the head word and fills the queue behind it.
`default_nettype none
`include "assert_macros.svh"

module utf8_cyrillic_to_byte_code (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  utfcyr_pkg::in_word_t  in_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output utfcyr_pkg::out_word_t out_word
);

  logic                              held_valid_r, held_valid_nxt;
  logic [7:0]                        held_byte_r, held_byte_nxt;
  utfcyr_pkg::out_word_t             fifo_r [utfcyr_pkg::FIFO_DEPTH];
  logic [utfcyr_pkg::PTR_W-1:0]      wr_ptr_r, rd_ptr_r;
  logic [utfcyr_pkg::CNT_W-1:0]      count_r, count_nxt;
  logic                              in_acc, out_acc;
  logic                              pair_hit;
  logic [7:0]                        pair_code;
  logic                              is_lead;
  logic [1:0]                        push_n;
  utfcyr_pkg::out_word_t             res0, res1;
  logic                              out_code_ok;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // Pair lookup of the held lead byte with the incoming byte.
  utfcyr_pair_dec u_pair_dec (
    .lead (held_byte_r),
    .tail (in_word.in_byte),
    .hit  (pair_hit),
    .code (pair_code)
  );

  assign is_lead = (in_word.in_byte == utfcyr_pkg::LEAD_LOW) ||
                   (in_word.in_byte == utfcyr_pkg::LEAD_HIGH);

  // Results of the accepted word and the next held lead byte.
  always_comb begin
    res0           = '{out_byte: in_word.in_byte, out_converted: 1'b0,
                       out_last: in_word.in_last};
    res1           = res0;
    push_n         = 2'd0;
    held_valid_nxt = held_valid_r;
    held_byte_nxt  = held_byte_r;
    if (in_acc) begin
      held_valid_nxt = 1'b0;
      held_byte_nxt  = 8'd0;
      if (held_valid_r && pair_hit) begin
        res0   = '{out_byte: pair_code, out_converted: 1'b1,
                   out_last: in_word.in_last};
        push_n = 2'd1;
      end else begin
        // A broken pair first releases the held lead byte unchanged.
        if (held_valid_r) begin
          res0 = '{out_byte: held_byte_r, out_converted: 1'b0, out_last: 1'b0};
        end
        if (is_lead && !in_word.in_last) begin
          held_valid_nxt = 1'b1;
          held_byte_nxt  = in_word.in_byte;
          push_n         = held_valid_r ? 2'd1 : 2'd0;
        end else begin
          push_n = held_valid_r ? 2'd2 : 2'd1;
        end
      end
    end
  end

  // Queue occupancy after this cycle's pushes and pop.
  assign count_nxt = count_r + utfcyr_pkg::CNT_W'(push_n)
                     - utfcyr_pkg::CNT_W'(out_acc);

  // Held lead byte and queue pointers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r <= 1'b0;
      held_byte_r  <= 8'd0;
      wr_ptr_r     <= '0;
      rd_ptr_r     <= '0;
      count_r      <= '0;
    end else begin
      held_valid_r <= held_valid_nxt;
      held_byte_r  <= held_byte_nxt;
      wr_ptr_r     <= wr_ptr_r + utfcyr_pkg::PTR_W'(push_n);
      rd_ptr_r     <= rd_ptr_r + utfcyr_pkg::PTR_W'(out_acc);
      count_r      <= count_nxt;
    end
  end

  // Queue storage: up to two words are written at the tail.
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      fifo_r[wr_ptr_r] <= res0;
    end
    if (push_n == 2'd2) begin
      fifo_r[wr_ptr_r + utfcyr_pkg::PTR_W'(1)] <= res1;
    end
  end

  // Room for two words is needed before an input word is taken.
  assign in_stall  = (count_r > utfcyr_pkg::CNT_W'(utfcyr_pkg::FIFO_DEPTH - 2));
  assign out_valid = (count_r != '0);
  assign out_word  = fifo_r[rd_ptr_r];

  // A converted word always carries a letter code.
  assign out_code_ok = (out_word.out_byte >= utfcyr_pkg::CODE_MIN) &&
                       (out_word.out_byte <= utfcyr_pkg::CODE_MAX);

  `ASSERT_NEVER(a_count_bound, clk, rst_n, count_r > utfcyr_pkg::CNT_W'(utfcyr_pkg::FIFO_DEPTH))
  `ASSERT_ALWAYS(a_last_clears_held, clk, rst_n, (in_acc && in_word.in_last) |=> !held_valid_r)
  `ASSERT_ALWAYS(a_code_range, clk, rst_n, (out_valid && out_word.out_converted) |-> out_code_ok)

endmodule

`default_nettype wire

// ===== bench/cyr_code_checker.sv =====
// Checker for the Cyrillic byte code converter: watches both word channels,
// predicts each output word and compares it with what the block emits.
// Depends on utfcyr_pkg for the word types and the lead byte constants.
`timescale 1ns / 100ps

module cyr_code_checker (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  utfcyr_pkg::in_word_t  in_word,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  utfcyr_pkg::out_word_t out_word,
  output int                    fail_count,
  output int                    pending
);

  localparam logic [7:0] NO_LETTER = 8'd0;

  // Folded code by offset from capital A; CHE sits ahead of HA and TSE.
  localparam logic [7:0] FOLD_CODE [0:31] = '{
    8'd192, 8'd193, 8'd194, 8'd195, 8'd196, 8'd197, 8'd199, 8'd200,
    8'd201, 8'd202, 8'd203, 8'd204, 8'd205, 8'd206, 8'd207, 8'd208,
    8'd209, 8'd210, 8'd211, 8'd212, 8'd213, 8'd215, 8'd216, 8'd214,
    8'd217, 8'd218, 8'd221, 8'd220, 8'd219, 8'd222, 8'd223, 8'd224
  };

  utfcyr_pkg::out_word_t code_q[$];
  logic [7:0]            lead_byte;
  logic                  lead_held;

  // Returns the one-byte code of a lead and tail pair, or NO_LETTER.
  function automatic logic [7:0] letter_code(logic [7:0] lead, logic [7:0] tail);
    logic [10:0] cp;
    if (tail[7:6] != 2'b10) return NO_LETTER;
    if (lead == utfcyr_pkg::LEAD_LOW) cp = 11'h400 | {5'd0, tail[5:0]};
    else if (lead == utfcyr_pkg::LEAD_HIGH) cp = 11'h440 | {5'd0, tail[5:0]};
    else return NO_LETTER;
    if (cp == 11'h401 || cp == 11'h451) return utfcyr_pkg::CODE_IO;
    // Both case blocks start 16 past a multiple of 32, so bit 4 flips.
    if (cp >= 11'h410 && cp <= 11'h44F) return FOLD_CODE[{~cp[4], cp[3:0]}];
    return NO_LETTER;
  endfunction

  // Queues the words that one accepted input word causes.
  task automatic predict_words(utfcyr_pkg::in_word_t w);
    logic [7:0]            code;
    logic [7:0]            lead;
    utfcyr_pkg::out_word_t r;
    if (lead_held) begin
      lead = lead_byte;
      code = letter_code(lead, w.in_byte);
      lead_held = 1'b0;
      lead_byte = 8'd0;
      if (code != NO_LETTER) begin
        r.out_byte      = code;
        r.out_converted = 1'b1;
        r.out_last      = w.in_last;
        code_q.push_back(r);
        return;
      end
      // Broken pair: the held lead goes out as it came in.
      r.out_byte      = lead;
      r.out_converted = 1'b0;
      r.out_last      = 1'b0;
      code_q.push_back(r);
    end
    if ((w.in_byte == utfcyr_pkg::LEAD_LOW || w.in_byte == utfcyr_pkg::LEAD_HIGH) &&
        !w.in_last) begin
      lead_byte = w.in_byte;
      lead_held = 1'b1;
      return;
    end
    r.out_byte      = w.in_byte;
    r.out_converted = 1'b0;
    r.out_last      = w.in_last;
    code_q.push_back(r);
  endtask

  task automatic report_mismatch(string what, logic [7:0] want, logic [7:0] got);
    if (fail_count < 100)
      $display("%0t ns: %s: expected 0x%02h, got 0x%02h", $time, what, want, got);
    fail_count++;
  endtask

  // Outputs are checked before the input side adds words, since a word
  // taken at this edge cannot leave the block at the same edge.
  always @(posedge clk) begin
    utfcyr_pkg::out_word_t want;
    if (!rst_n) begin
      lead_held  = 1'b0;
      lead_byte  = 8'd0;
      fail_count = 0;
      code_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (code_q.size() == 0) begin
          report_mismatch("word with nothing expected", 8'd0, out_word.out_byte);
        end else begin
          want = code_q.pop_front();
          if (out_word.out_byte != want.out_byte)
            report_mismatch("out_byte", want.out_byte, out_word.out_byte);
          if (out_word.out_converted != want.out_converted)
            report_mismatch("out_converted", 8'(want.out_converted),
                            8'(out_word.out_converted));
          if (out_word.out_last != want.out_last)
            report_mismatch("out_last", 8'(want.out_last), 8'(out_word.out_last));
        end
      end
      if (in_valid && !in_stall) begin
        predict_words(in_word);
      end
    end
    pending <= code_q.size();
  end

endmodule

// ===== bench/tb_top.sv =====
// Top of the testbench for utf8_cyrillic_to_byte_code: drives the byte stream
// and the output stall, and gives the verdict. Depends on utfcyr_pkg and cyr_code_checker.
`timescale 1ns / 100ps

module tb_top;

  localparam int ITEM_COUNT = 1150;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  utfcyr_pkg::in_word_t  in_word   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  utfcyr_pkg::out_word_t out_word;
  logic                  calm      = 1'b0;
  int                    fail_count;
  int                    pending;
  int                    items_sent = 0;

  always #1 clk = ~clk;

  utf8_cyrillic_to_byte_code dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  cyr_code_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // The receiver stalls at random outside the calm stretch.
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 30);
  end

  // Sends one byte, with random idle cycles ahead of it outside the calm stretch.
  task automatic push_byte(logic [7:0] b, logic last);
    utfcyr_pkg::in_word_t w;
    while (!calm && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    w.in_byte = b;
    w.in_last = last;
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  function automatic logic rare_last();
    return $urandom_range(11) == 0;
  endfunction

  // Sends the UTF-8 pair of a code point on the two Cyrillic pages.
  task automatic push_pair(logic [10:0] cp);
    push_byte(cp < 11'h440 ? utfcyr_pkg::LEAD_LOW : utfcyr_pkg::LEAD_HIGH,
              $urandom_range(39) == 0);
    push_byte({2'b10, cp[5:0]}, rare_last());
  endtask

  // Mostly well-formed letters of either case, the rest noise and broken pairs.
  task automatic push_random();
    int kind;
    kind = $urandom_range(99);
    if (kind < 60) begin
      if ($urandom_range(15) == 0) push_pair($urandom_range(1) ? 11'h401 : 11'h451);
      else push_pair(11'h410 + 11'($urandom_range(63)));
    end else if (kind < 70) begin
      push_pair(11'h400 + 11'($urandom_range(127)));
    end else if (kind < 80) begin
      push_byte($urandom_range(1) ? utfcyr_pkg::LEAD_HIGH : utfcyr_pkg::LEAD_LOW,
                rare_last());
      push_byte(8'($urandom_range(255)), rare_last());
    end else if (kind < 90) begin
      push_byte(8'($urandom_range(126, 32)), rare_last());
    end else begin
      push_byte(8'($urandom_range(255)), rare_last());
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Plain bytes at the extremes, zero byte among them.
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b1);
    // Letters: capital A, small YA, both cases of IO, CHE out of order, capital YA.
    push_byte(utfcyr_pkg::LEAD_LOW, 1'b0);  push_byte(8'h90, 1'b0);
    push_byte(utfcyr_pkg::LEAD_HIGH, 1'b0); push_byte(8'h8F, 1'b0);
    push_byte(utfcyr_pkg::LEAD_LOW, 1'b0);  push_byte(8'h81, 1'b0);
    push_byte(utfcyr_pkg::LEAD_HIGH, 1'b0); push_byte(8'h91, 1'b0);
    push_byte(utfcyr_pkg::LEAD_LOW, 1'b0);  push_byte(8'hA7, 1'b0);
    push_byte(utfcyr_pkg::LEAD_LOW, 1'b0);  push_byte(8'hAF, 1'b1);
    // Broken pairs: a tail that is no continuation, and one that is no letter.
    push_byte(utfcyr_pkg::LEAD_LOW, 1'b0);  push_byte(8'h41, 1'b0);
    push_byte(utfcyr_pkg::LEAD_LOW, 1'b0);  push_byte(8'h80, 1'b0);
    // Leads in a row, the last of them completed as small ER.
    push_byte(utfcyr_pkg::LEAD_HIGH, 1'b0); push_byte(utfcyr_pkg::LEAD_LOW, 1'b0);
    push_byte(utfcyr_pkg::LEAD_HIGH, 1'b0); push_byte(8'h80, 1'b0);
    // A lead that ends the string, then a broken pair whose tail ends it.
    push_byte(utfcyr_pkg::LEAD_LOW, 1'b1);
    push_byte(utfcyr_pkg::LEAD_HIGH, 1'b0); push_byte(8'hBF, 1'b1);
    // A letter whose tail ends the string.
    push_byte(utfcyr_pkg::LEAD_LOW, 1'b0);  push_byte(8'hB0, 1'b1);

    // Let the output side drain completely before the random stream.
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);

    while (items_sent < ITEM_COUNT) begin
      calm <= (items_sent >= 450 && items_sent < 700);
      push_random();
    end
    in_valid <= 1'b0;
    calm     <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    #400000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== utf8_cyrillic_to_byte_code.f =====
+incdir+hdl
hdl/utfcyr_pkg.sv
hdl/utfcyr_pair_dec.sv
hdl/utf8_cyrillic_to_byte_code.sv
bench/cyr_code_checker.sv
bench/tb_top.sv
